/* design/wfa_pkg.sv */
// Shared types and constants for the water-filling token allocator.
// Holds the slot record carried along the cell chain and the register indexes.
// Depends on nothing; every other design file imports it.
package wfa_pkg;

    // Data widths fixed by the block's interface.
    localparam int DATA_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int IDX_OUT_W   = 4;
    localparam int CFG_IDX_W   = 2;

    // Default number of slot cells.
    localparam int NUM_SLOTS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK      = 2'd1;

    // Configuration reset values.
    localparam logic [DATA_W-1:0] BATCH_CAPACITY_RST = 16'd2048;
    localparam logic [DATA_W-1:0] MAX_CHUNK_RST      = 16'd512;

    // One loaded slot as it travels around the ring of cells.
    typedef struct packed {
        logic              valid;
        logic              active;
        logic              prefill;
        logic              served;
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] grant;
    } t_slot_rec;

endpackage

/* design/wfa_cell.sv */
// One storage cell of the slot ring: holds a single slot record.
// On every shift it takes the record of its upstream neighbor.
// Depends on wfa_pkg for the record type.
module wfa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  wfa_pkg::t_slot_rec i_rec,
    output wfa_pkg::t_slot_rec o_rec
);
    import wfa_pkg::*;

    logic      r_valid;
    t_slot_rec r_rec;

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_rec.valid;
        end
    end

    // The record payload only moves on a shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    // Present the stored record with its reset-safe valid flag.
    always_comb begin
        o_rec       = r_rec;
        o_rec.valid = r_valid;
    end

endmodule

/* design/wfa_div.sv */
// Restoring divider that produces the per-round fair share.
// One quotient bit per cycle.
// Depends on wfa_pkg for the default data width.
module wfa_div #(
    parameter int DW = wfa_pkg::DATA_W,
    parameter int SW = wfa_pkg::COUNT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    import wfa_pkg::*;

    localparam int CNW = $clog2(DW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [SW-1:0]  r_rem;
    logic [DW-1:0]  r_q;
    logic [SW-1:0]  r_div;

    logic [SW:0]    w_trial;
    logic [SW:0]    w_diff;
    logic           w_ge;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_trial = {r_rem, r_q[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // Iteration control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DW);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
                r_q   <= {r_q[DW-2:0], w_ge};
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* design/water_filling_token_allocator_core.sv */
// Top level of the max-min fair water-filling token allocator.
// Instantiates the ring of wfa_cell slot cells and the wfa_div share divider.
// Depends on wfa_pkg for types, widths and register indexes.
//
//   Channel   Direction  Handshake                     Payload
//   -------   ---------  ----------------------------  --------------------------------------
//   slot in   in         start high, busy low          i_active, i_pending, i_prefilling,
//                                                      i_last_slot
//   config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//   result    out        o_result_valid, one cycle     o_slot_index ... o_last_result
//
// Slot items load one per cycle into the cell ring while busy is low. The item with
// last_slot set raises busy through a check state, R fair-share rounds (R at most
// the active count, zero for a starved run), an equal-share pass when a round serves
// no slot, and the output trip. Each round is a division (start, 16 quotient bits,
// handoff) plus one full trip of the ring. Results leave during the output trip, one
// per loaded slot in load order. Reset is synchronous and active low and restores the
// configuration defaults. The result receiver cannot stall; the config port is always
// ready; the user must write it only while busy is low, which the block does not enforce.
module water_filling_token_allocator_core #(
    parameter int NUM_SLOTS = wfa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slot item transaction.
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_active,
    input  logic [wfa_pkg::DATA_W-1:0]      i_pending,
    input  logic                            i_prefilling,
    input  logic                            i_last_slot,
    // Configuration transaction.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wfa_pkg::DATA_W-1:0]      i_cfg_data,
    // Result transaction.
    output logic                            o_result_valid,
    output logic [wfa_pkg::IDX_OUT_W-1:0]   o_slot_index,
    output logic [wfa_pkg::DATA_W-1:0]      o_grant,
    output logic [wfa_pkg::DATA_W-1:0]      o_total_tokens,
    output logic [wfa_pkg::DATA_W-1:0]      o_prefill_tokens,
    output logic [wfa_pkg::DATA_W-1:0]      o_decode_tokens,
    output logic [wfa_pkg::COUNT_W-1:0]     o_active_count,
    output logic [wfa_pkg::COUNT_W-1:0]     o_prefilling_count,
    output logic                            o_starved,
    output logic                            o_last_result
);
    import wfa_pkg::*;

    localparam int CW  = $clog2(NUM_SLOTS + 1);
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIT,
        ST_FILL,
        ST_OUT
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_cap;
    logic [DATA_W-1:0] r_max_chunk;
    logic [CW-1:0]     r_loaded;
    logic [CW-1:0]     r_nact;
    logic [CW-1:0]     r_npre;
    logic [CW-1:0]     r_unserved;
    logic [CW-1:0]     r_pos;
    logic [CXW-1:0]    r_idx;
    logic              r_any;
    logic              r_starved;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_share;
    logic [DATA_W-1:0] r_tot;
    logic [DATA_W-1:0] r_ptok;
    logic [DATA_W-1:0] r_dtok;

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_index;
    logic [DATA_W-1:0]    r_out_grant;
    logic [DATA_W-1:0]    r_out_tot;
    logic [DATA_W-1:0]    r_out_ptok;
    logic [DATA_W-1:0]    r_out_dtok;
    logic [COUNT_W-1:0]   r_out_nact;
    logic [COUNT_W-1:0]   r_out_npre;
    logic                 r_out_starved;
    logic                 r_out_last;

    t_slot_rec         w_ring [NUM_SLOTS];
    t_slot_rec         w_ring_in;
    t_slot_rec         w_new;
    t_slot_rec         w_back;
    t_slot_rec         w_tail;
    logic              w_accept;
    logic              w_load;
    logic              w_pass;
    logic              w_shift;
    logic              w_pass_end;
    logic              w_fit_hit;
    logic              w_fill_hit;
    logic              w_hit;
    logic [DATA_W-1:0] w_take;
    logic [CW-1:0]     w_unserved_nx;
    logic              w_any_nx;
    logic              w_starve;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic [CXW-1:0]    w_nact_x;
    logic [CXW-1:0]    w_npre_x;
    logic [CXW-1:0]    w_idx_nx;

    // Configuration registers; user must write only while the block is idle (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= BATCH_CAPACITY_RST;
            r_max_chunk <= MAX_CHUNK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BATCH_CAPACITY: r_cap       <= i_cfg_data;
                CFG_MAX_CHUNK:      r_max_chunk <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Handshake and ring movement.
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (r_loaded < CW'(NUM_SLOTS));
    assign w_pass   = (r_state == ST_FIT) || (r_state == ST_FILL) || (r_state == ST_OUT);
    assign w_shift  = w_load || w_pass;
    assign w_pass_end = w_pass && (r_pos == CW'(NUM_SLOTS - 1));
    assign w_tail   = w_ring[NUM_SLOTS-1];

    // New slot record: an inactive slot counts as served from the start.
    always_comb begin
        w_new.valid   = 1'b1;
        w_new.active  = i_active;
        w_new.prefill = i_prefilling;
        w_new.served  = !i_active;
        w_new.want    = (i_pending < r_max_chunk) ? i_pending : r_max_chunk;
        w_new.grant   = '0;
    end

    // Round decision for the record leaving the tail of the ring.
    assign w_fit_hit  = (r_state == ST_FIT) && w_tail.valid && !w_tail.served &&
                        (w_tail.want <= r_share);
    assign w_fill_hit = (r_state == ST_FILL) && w_tail.valid && !w_tail.served;
    assign w_hit      = w_fit_hit || w_fill_hit;
    assign w_take     = w_fit_hit ? w_tail.want : r_share;
    assign w_unserved_nx = w_fit_hit ? (r_unserved - CW'(1)) : r_unserved;
    assign w_any_nx      = r_any || w_fit_hit;

    // Record written back into the head cell; the output trip retires it.
    always_comb begin
        w_back = w_tail;
        if (w_hit) begin
            w_back.grant  = w_take;
            w_back.served = 1'b1;
        end
        if (r_state == ST_OUT) begin
            w_back.valid = 1'b0;
        end
    end

    assign w_ring_in = (r_state == ST_IDLE) ? w_new : w_back;

    // Ring of slot cells, each fed by its upstream neighbor.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            wfa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_rec   (w_ring_in),
                .o_rec   (w_ring[g])
            );
        end else begin : g_body
            wfa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_rec   (w_ring[g-1]),
                .o_rec   (w_ring[g])
            );
        end
    end

    // Share divider: tokens left over the slots still unserved.
    assign w_div_start = (r_state == ST_DIV_START);

    wfa_div #(
        .DW (DATA_W),
        .SW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_left),
        .i_divisor  (r_unserved),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Starvation check and result field widths.
    assign w_starve = (r_nact == '0) || (r_cap < DATA_W'(r_nact));
    assign w_nact_x = CXW'(r_nact);
    assign w_npre_x = CXW'(r_npre);
    assign w_idx_nx = r_idx + CXW'(1);

    // Sequencer: loading, rounds of fit passes, the equal-share pass and the output trip.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loaded    <= '0;
            r_nact      <= '0;
            r_npre      <= '0;
            r_unserved  <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_starved   <= 1'b0;
            r_tot       <= '0;
            r_ptok      <= '0;
            r_dtok      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_loaded <= r_loaded + CW'(1);
                        if (i_active) begin
                            r_nact <= r_nact + CW'(1);
                        end
                        if (i_active && i_prefilling) begin
                            r_npre <= r_npre + CW'(1);
                        end
                    end
                    if (w_accept && i_last_slot) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_starved  <= w_starve;
                    r_left     <= r_cap;
                    r_unserved <= w_starve ? '0 : r_nact;
                    r_pos      <= '0;
                    r_idx      <= '0;
                    r_state    <= w_starve ? ST_OUT : ST_DIV_START;
                end
                ST_DIV_START: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_share <= w_quot;
                        r_any   <= 1'b0;
                        r_pos   <= '0;
                        r_state <= ST_FIT;
                    end
                end
                ST_FIT: begin
                    r_pos      <= r_pos + CW'(1);
                    r_unserved <= w_unserved_nx;
                    r_any      <= w_any_nx;
                    if (w_fit_hit) begin
                        r_left <= r_left - w_take;
                        r_tot  <= r_tot + w_take;
                        if (w_tail.prefill) begin
                            r_ptok <= r_ptok + w_take;
                        end else begin
                            r_dtok <= r_dtok + w_take;
                        end
                    end
                    if (w_pass_end) begin
                        r_pos <= '0;
                        if (w_unserved_nx == '0) begin
                            r_state <= ST_OUT;
                        end else if (!w_any_nx) begin
                            r_state <= ST_FILL;
                        end else begin
                            r_state <= ST_DIV_START;
                        end
                    end
                end
                ST_FILL: begin
                    r_pos <= r_pos + CW'(1);
                    if (w_fill_hit) begin
                        r_tot <= r_tot + w_take;
                        if (w_tail.prefill) begin
                            r_ptok <= r_ptok + w_take;
                        end else begin
                            r_dtok <= r_dtok + w_take;
                        end
                    end
                    if (w_pass_end) begin
                        r_pos      <= '0;
                        r_unserved <= '0;
                        r_state    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_pos <= r_pos + CW'(1);
                    if (w_tail.valid) begin
                        r_out_valid   <= 1'b1;
                        r_out_index   <= r_idx[IDX_OUT_W-1:0];
                        r_out_grant   <= w_tail.grant;
                        r_out_tot     <= r_tot;
                        r_out_ptok    <= r_ptok;
                        r_out_dtok    <= r_dtok;
                        r_out_nact    <= w_nact_x[COUNT_W-1:0];
                        r_out_npre    <= w_npre_x[COUNT_W-1:0];
                        r_out_starved <= r_starved;
                        r_out_last    <= (w_idx_nx == CXW'(r_loaded));
                        r_idx         <= w_idx_nx;
                    end
                    if (w_pass_end) begin
                        r_pos    <= '0;
                        r_loaded <= '0;
                        r_nact   <= '0;
                        r_npre   <= '0;
                        r_tot    <= '0;
                        r_ptok   <= '0;
                        r_dtok   <= '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result ports.
    assign o_result_valid     = r_out_valid;
    assign o_slot_index       = r_out_index;
    assign o_grant            = r_out_grant;
    assign o_total_tokens     = r_out_tot;
    assign o_prefill_tokens   = r_out_ptok;
    assign o_decode_tokens    = r_out_dtok;
    assign o_active_count     = r_out_nact;
    assign o_prefilling_count = r_out_npre;
    assign o_starved          = r_out_starved;
    assign o_last_result      = r_out_last;

    // A result only comes out of the output trip of the ring.
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_OUT))
        else $error("result strobe outside the output trip");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // Unserved slots never outnumber the active slots of the run.
    a_unserved_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unserved <= r_nact)
        else $error("unserved count exceeds active count");

    // A fit pass that serves nobody leads to the equal-share pass.
    a_fit_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pass_end && (r_state == ST_FIT) && !w_any_nx) |=> (r_state == ST_FILL))
        else $error("stalled round did not move to the equal-share pass");

endmodule

/* bench/water_filling_token_allocator_core_test.sv */
// Self-checking bench for water_filling_token_allocator_core.
// Loads slot runs through the start/busy port, predicts the water-filled grants with a
// scoreboard class, and checks every result strobe; depends on wfa_pkg and the RTL.
import wfa_pkg::*;

// One result transaction, field by field as it leaves the block.
typedef struct packed {
    logic [IDX_OUT_W-1:0] slot_index;
    logic [DATA_W-1:0]    grant;
    logic [DATA_W-1:0]    total_tokens;
    logic [DATA_W-1:0]    prefill_tokens;
    logic [DATA_W-1:0]    decode_tokens;
    logic [COUNT_W-1:0]   active_count;
    logic [COUNT_W-1:0]   prefilling_count;
    logic                 starved;
    logic                 last_result;
} t_grant_rec;

// Tracks loaded slots and the register file, and queues the grants each run should produce.
class water_fill_ledger;
    logic [DATA_W-1:0] capacity;
    logic [DATA_W-1:0] max_chunk;
    logic [DATA_W-1:0] want [NUM_SLOTS_DEF];
    logic [DATA_W-1:0] granted [NUM_SLOTS_DEF];
    bit                slot_active [NUM_SLOTS_DEF];
    bit                slot_prefill [NUM_SLOTS_DEF];
    int unsigned       loaded;
    bit                run_overflowed;
    t_grant_rec        expected_grants [$];
    int unsigned       errors;
    int unsigned       n_items;
    int unsigned       n_runs;
    int unsigned       n_starved;
    int unsigned       n_dropped;
    int unsigned       n_checked;
    int unsigned       n_writes;

    function new();
        capacity       = BATCH_CAPACITY_RST;
        max_chunk      = MAX_CHUNK_RST;
        loaded         = 0;
        run_overflowed = 1'b0;
        errors         = 0;
        n_items        = 0;
        n_runs         = 0;
        n_starved      = 0;
        n_dropped      = 0;
        n_checked      = 0;
        n_writes       = 0;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            want[i]         = '0;
            granted[i]      = '0;
            slot_active[i]  = 1'b0;
            slot_prefill[i] = 1'b0;
        end
    endfunction

    // A register write; indexes outside the register file are ignored by the block.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        n_writes++;
        if (idx == CFG_BATCH_CAPACITY) begin
            capacity = val;
        end else if (idx == CFG_MAX_CHUNK) begin
            max_chunk = val;
        end
    endfunction

    // Max-min fair split of the capacity over the active loaded slots.
    function void fill_water(int unsigned nact);
        int unsigned unserved;
        int unsigned left;
        int unsigned share;
        bit          served [NUM_SLOTS_DEF];
        bit          progress;
        unserved = nact;
        left     = capacity;
        for (int i = 0; i < loaded; i++) begin
            served[i] = !slot_active[i];
        end
        while (unserved > 0) begin
            share    = left / unserved;
            progress = 1'b0;
            // Every slot whose want fits this round's share takes its want.
            for (int i = 0; i < loaded; i++) begin
                if (!served[i] && want[i] <= share) begin
                    granted[i] = want[i];
                    left       = left - want[i];
                    served[i]  = 1'b1;
                    unserved--;
                    progress   = 1'b1;
                end
            end
            // Nobody fit, so everyone left gets the equal share.
            if (!progress) begin
                for (int i = 0; i < loaded; i++) begin
                    if (!served[i]) begin
                        granted[i] = share[DATA_W-1:0];
                        left       = left - share;
                        served[i]  = 1'b1;
                    end
                end
                unserved = 0;
            end
        end
    endfunction

    // Notes one accepted slot transaction; the last one of a run queues its grants.
    function void note_slot(bit act, logic [DATA_W-1:0] pend, bit pre, bit last);
        int unsigned nact;
        int unsigned npre;
        int unsigned tot;
        int unsigned ptok;
        int unsigned dtok;
        bit          starved;
        t_grant_rec  rec;
        n_items++;
        if (loaded < NUM_SLOTS_DEF) begin
            want[loaded]         = (pend < max_chunk) ? pend : max_chunk;
            slot_active[loaded]  = act;
            slot_prefill[loaded] = pre;
            loaded++;
        end else begin
            run_overflowed = 1'b1;
        end
        if (!last) return;

        nact = 0;
        npre = 0;
        for (int i = 0; i < loaded; i++) begin
            granted[i] = '0;
            if (slot_active[i]) begin
                nact++;
                if (slot_prefill[i]) npre++;
            end
        end
        starved = (nact == 0) || (capacity < nact);
        if (!starved) fill_water(nact);

        // Run totals over the active slots.
        tot  = 0;
        ptok = 0;
        dtok = 0;
        for (int i = 0; i < loaded; i++) begin
            if (slot_active[i]) begin
                tot = tot + granted[i];
                if (slot_prefill[i]) ptok = ptok + granted[i];
                else dtok = dtok + granted[i];
            end
        end

        for (int i = 0; i < loaded; i++) begin
            rec.slot_index       = i[IDX_OUT_W-1:0];
            rec.grant            = granted[i];
            rec.total_tokens     = tot[DATA_W-1:0];
            rec.prefill_tokens   = ptok[DATA_W-1:0];
            rec.decode_tokens    = dtok[DATA_W-1:0];
            rec.active_count     = nact[COUNT_W-1:0];
            rec.prefilling_count = npre[COUNT_W-1:0];
            rec.starved          = starved;
            rec.last_result      = (i + 1 == loaded);
            expected_grants      = {expected_grants, rec};
        end
        n_runs++;
        if (starved) n_starved++;
        if (run_overflowed) n_dropped++;
        loaded         = 0;
        run_overflowed = 1'b0;
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Checks one result transaction against the oldest queued grant.
    function void check_grant(t_grant_rec got);
        t_grant_rec exp;
        if (expected_grants.size() == 0) begin
            $error("result for slot %0d arrived with no grant outstanding", got.slot_index);
            errors++;
            return;
        end
        exp = expected_grants.pop_front();
        n_checked++;
        compare_field("slot_index", exp.slot_index, got.slot_index);
        compare_field("grant", exp.grant, got.grant);
        compare_field("total_tokens", exp.total_tokens, got.total_tokens);
        compare_field("prefill_tokens", exp.prefill_tokens, got.prefill_tokens);
        compare_field("decode_tokens", exp.decode_tokens, got.decode_tokens);
        compare_field("active_count", exp.active_count, got.active_count);
        compare_field("prefilling_count", exp.prefilling_count, got.prefilling_count);
        compare_field("starved", exp.starved, got.starved);
        compare_field("last_result", exp.last_result, got.last_result);
    endfunction
endclass

module water_filling_token_allocator_core_test;

    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 18;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 24;
    localparam int RANDOM_PHASES = 7;
    localparam int STEADY_PHASE  = 3;

    // Register indexes past the end of the register file.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_active;
    logic [DATA_W-1:0]    i_pending;
    logic                 i_prefilling;
    logic                 i_last_slot;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 o_result_valid;
    logic [IDX_OUT_W-1:0] o_slot_index;
    logic [DATA_W-1:0]    o_grant;
    logic [DATA_W-1:0]    o_total_tokens;
    logic [DATA_W-1:0]    o_prefill_tokens;
    logic [DATA_W-1:0]    o_decode_tokens;
    logic [COUNT_W-1:0]   o_active_count;
    logic [COUNT_W-1:0]   o_prefilling_count;
    logic                 o_starved;
    logic                 o_last_result;

    water_fill_ledger ledger;
    bit               steady;

    water_filling_token_allocator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_active           (i_active),
        .i_pending          (i_pending),
        .i_prefilling       (i_prefilling),
        .i_last_slot        (i_last_slot),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_result_valid     (o_result_valid),
        .o_slot_index       (o_slot_index),
        .o_grant            (o_grant),
        .o_total_tokens     (o_total_tokens),
        .o_prefill_tokens   (o_prefill_tokens),
        .o_decode_tokens    (o_decode_tokens),
        .o_active_count     (o_active_count),
        .o_prefilling_count (o_prefilling_count),
        .o_starved          (o_starved),
        .o_last_result      (o_last_result)
    );

    // Clock with a period of 4 time units.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin : watch_results
        t_grant_rec seen;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            seen.slot_index       = o_slot_index;
            seen.grant            = o_grant;
            seen.total_tokens     = o_total_tokens;
            seen.prefill_tokens   = o_prefill_tokens;
            seen.decode_tokens    = o_decode_tokens;
            seen.active_count     = o_active_count;
            seen.prefilling_count = o_prefilling_count;
            seen.starved          = o_starved;
            seen.last_result      = o_last_result;
            ledger.check_grant(seen);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("water_filling_token_allocator_core: mismatch");
        $finish;
    end

    // Drives one slot transaction, with an occasional idle gap before it.
    task automatic send_slot(input bit act, input logic [DATA_W-1:0] pend,
                             input bit pre, input bit last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_active     <= act;
        i_pending    <= pend;
        i_prefilling <= pre;
        i_last_slot  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_slot(act, pend, pre, last);
        @(negedge i_clk);
    endtask

    // Drives one register write transaction; the caller drops valid afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        ledger.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] cap, input logic [DATA_W-1:0] chunk);
        write_reg(CFG_BATCH_CAPACITY, cap);
        write_reg(CFG_MAX_CHUNK, chunk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every queued grant has arrived and the block is idle, then a short pause.
    task automatic drain_grants(output bit drained);
        int unsigned waited;
        start  <= 1'b0;
        waited = 0;
        while ((ledger.expected_grants.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        drained = (ledger.expected_grants.size() == 0) && (busy === 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One random run of slot items, sometimes longer than the slot file so the tail drops.
    task automatic send_random_run(output int unsigned len);
        int unsigned       pick;
        bit                act;
        bit                pre;
        logic [DATA_W-1:0] pend;
        pick = $urandom_range(99);
        if (pick < 8) len = $urandom_range(NUM_SLOTS_DEF + 1, NUM_SLOTS_DEF + 4);
        else if (pick < 40) len = $urandom_range(1, 4);
        else len = $urandom_range(1, NUM_SLOTS_DEF);
        for (int i = 0; i < len; i++) begin
            act = ($urandom_range(99) < 85);
            pre = 1'($urandom_range(1));
            // Pending counts cluster at zero, one, small values, around the chunk limit and the top of the range.
            case ($urandom_range(5))
                0: pend = '0;
                1: pend = 16'd1;
                2: pend = DATA_W'($urandom_range(0, 15));
                3: pend = 16'hFFFF;
                4: pend = DATA_W'(ledger.max_chunk + $urandom_range(0, 2) - 1);
                default: pend = DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            send_slot(act, pend, pre, (i + 1 == len));
        end
    endtask

    initial begin
        bit                drained;
        int unsigned       run_len;
        int unsigned       phase_items;
        logic [DATA_W-1:0] cap;
        logic [DATA_W-1:0] chunk;

        ledger       = new();
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_active     = 1'b0;
        i_pending    = '0;
        i_prefilling = 1'b0;
        i_last_slot  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_BATCH_CAPACITY;
        i_cfg_data   = '0;

        // Synchronous reset, released on a falling clock edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a lone inactive slot leaves nothing active, so the run is starved.
        send_slot(1'b0, 16'h1234, 1'b1, 1'b1);
        // Directed: field extremes, a zero want, an inactive slot, default registers.
        send_slot(1'b1, 16'hFFFF, 1'b1, 1'b0);
        send_slot(1'b1, 16'h0000, 1'b0, 1'b0);
        send_slot(1'b0, 16'hFFFF, 1'b0, 1'b0);
        send_slot(1'b1, 16'h0001, 1'b0, 1'b0);
        send_slot(1'b1, 16'd300,  1'b1, 1'b1);
        drain_grants(drained);

        // Writes past the register file must be ignored; capacity drops below the active count.
        write_reg(CFG_SPARE_LO, DATA_W'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_SPARE_HI, DATA_W'($urandom_range(0, 16'hFFFF)));
        set_config(16'd3, 16'hFFFF);
        send_slot(1'b1, 16'd7,    1'b0, 1'b0);
        send_slot(1'b1, 16'd9,    1'b1, 1'b0);
        send_slot(1'b1, 16'hFFFF, 1'b0, 1'b0);
        send_slot(1'b1, 16'd2,    1'b1, 1'b1);
        // Nothing fits the first share, so every slot gets the equal share.
        send_slot(1'b1, 16'hFFFF, 1'b1, 1'b0);
        send_slot(1'b1, 16'd100,  1'b0, 1'b0);
        send_slot(1'b1, 16'hFFFF, 1'b0, 1'b1);
        drain_grants(drained);

        // A zero chunk limit makes every want zero.
        set_config(16'hFFFF, 16'h0000);
        send_slot(1'b1, 16'hFFFF, 1'b1, 1'b0);
        send_slot(1'b1, 16'd5,    1'b0, 1'b0);
        send_slot(1'b1, 16'd0,    1'b0, 1'b1);
        drain_grants(drained);

        // Two water-filling rounds and then the equal-share pass over a staircase of wants.
        set_config(16'd1000, 16'hFFFF);
        send_slot(1'b1, 16'd100, 1'b0, 1'b0);
        send_slot(1'b1, 16'd200, 1'b1, 1'b0);
        send_slot(1'b1, 16'd300, 1'b0, 1'b0);
        send_slot(1'b1, 16'd400, 1'b1, 1'b0);
        send_slot(1'b1, 16'd500, 1'b0, 1'b0);
        send_slot(1'b1, 16'd600, 1'b1, 1'b1);
        drain_grants(drained);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin cap = BATCH_CAPACITY_RST; chunk = MAX_CHUNK_RST; end
                1: begin cap = 16'd0;    chunk = 16'd1;    end
                2: begin cap = 16'hFFFF; chunk = 16'hFFFF; end
                3: begin cap = 16'd1;    chunk = 16'hFFFF; end
                4: begin
                    cap   = DATA_W'($urandom_range(1, 40));
                    chunk = DATA_W'($urandom_range(1, 20));
                end
                default: begin
                    cap   = DATA_W'($urandom_range(16, 6000));
                    chunk = DATA_W'($urandom_range(1, 1500));
                end
            endcase
            set_config(cap, chunk);
            steady      = (phase == STEADY_PHASE);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_run(run_len);
                phase_items = phase_items + run_len;
            end
            drain_grants(drained);
        end
        steady = 1'b0;

        drain_grants(drained);
        if (!drained) begin
            $display("water_filling_token_allocator_core: mismatch");
            $finish;
        end else begin
            $display("Loaded %0d slot items in %0d runs (%0d starved, %0d with dropped slots).",
                     ledger.n_items, ledger.n_runs, ledger.n_starved, ledger.n_dropped);
            $display("Checked %0d grants across %0d register writes.",
                     ledger.n_checked, ledger.n_writes);
            if (ledger.errors == 0) begin
                $display("water_filling_token_allocator_core: match");
            end else begin
                $display("water_filling_token_allocator_core: mismatch");
            end
            $finish;
        end
    end

endmodule
